FILE: sv/sfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_pkg
// shared types, codes and helpers of the sensor frame decoder
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam logic [10:0] ID_BASE  = 11'h520;
  localparam logic [10:0] ID_FIRST = 11'h521;
  localparam logic [10:0] ID_LAST  = 11'h528;

  localparam logic [1:0] CFG_WARMUP = 2'd0;
  localparam logic [1:0] CFG_SPLIT  = 2'd1;
  localparam logic [1:0] CFG_FLOOR  = 2'd2;

  localparam logic [15:0] WARMUP_RESET = 16'd150;
  localparam logic [30:0] SPLIT_RESET  = 31'd3000;
  localparam logic [30:0] FLOOR_RESET  = 31'd10000;

  localparam logic [15:0] FRAMES_MAX = 16'hFFFF;

  localparam int unsigned MARK_PACK_LO = 0;
  localparam int unsigned MARK_PACK_HI = 1;
  localparam int unsigned MARK_V1_LO   = 2;
  localparam int unsigned MARK_V1_HI   = 3;
  localparam int unsigned MARK_V2_LO   = 4;
  localparam int unsigned MARK_V2_HI   = 5;
  localparam int unsigned MARK_V3_LO   = 6;
  localparam int unsigned MARK_V3_HI   = 7;
  localparam int unsigned MARK_COUNT   = 8;

  typedef enum logic [3:0] {
    KIND_IGNORED = 4'd0,
    KIND_CURRENT = 4'd1,
    KIND_PACK    = 4'd2,
    KIND_VOLT2   = 4'd3,
    KIND_VOLT3   = 4'd4,
    KIND_TEMP    = 4'd5,
    KIND_POWER   = 4'd6,
    KIND_CHARGE  = 4'd7,
    KIND_ENERGY  = 4'd8
  } kind_t;

  typedef struct packed {
    logic [15:0] warmup_frames;
    logic [30:0] split_threshold_mv;
    logic [30:0] low_floor_mv;
  } cfg_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [47:0] main_value;
    logic signed [31:0] derived_value;
    logic signed [31:0] low_mark;
    logic signed [31:0] high_mark;
    logic signed [31:0] derived_low;
    logic signed [31:0] derived_high;
    logic [15:0]        frames_seen;
  } res_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (!v[33] && (v[32] || v[31])) begin
      r = {1'b0, {31{1'b1}}};
    end else if (v[33] && !(v[32] && v[31])) begin
      r = {1'b1, {31{1'b0}}};
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
    logic signed [47:0] r;
    if (!v[48] && v[47]) begin
      r = {1'b0, {47{1'b1}}};
    end else if (v[48] && !v[47]) begin
      r = {1'b1, {47{1'b0}}};
    end else begin
      r = v[47:0];
    end
    return r;
  endfunction

endpackage

FILE: sv/sfd_div10.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_div10
// signed divide by ten, truncating toward zero, by reciprocal multiply
// ----------------------------------------------------------------------------
module sfd_div10 (
  input  logic signed [31:0] din,
  output logic signed [31:0] quo
);

  localparam logic [31:0] RECIP10 = 32'hCCCCCCCD;

  logic [31:0] mag;
  logic [63:0] prod;
  logic [28:0] qmag;

  always_comb begin
    mag  = din[31] ? (32'd0 - din) : din;
    prod = 64'(mag) * 64'(RECIP10);
    qmag = prod[63:35];
    quo  = din[31] ? (32'sd0 - 32'($signed({1'b0, qmag}))) : 32'($signed({1'b0, qmag}));
  end

endmodule

FILE: sv/sfd_state.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_state
// measurement state, mark tracking and accumulators; builds one result
// ----------------------------------------------------------------------------
module sfd_state (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic [10:0]       msg_id,
  input  logic signed [31:0] raw,
  input  sfd_pkg::cfg_t     cfg,
  output sfd_pkg::res_t     res,
  output logic [15:0]       frame_total
);

  logic [15:0]        total_r, total_nxt;
  logic signed [31:0] pack_r, pack_nxt;
  logic signed [31:0] second_r, second_nxt;
  logic signed [31:0] third_r, third_nxt;
  logic signed [31:0] marks_r [sfd_pkg::MARK_COUNT];
  logic signed [31:0] marks_nxt [sfd_pkg::MARK_COUNT];
  logic signed [31:0] last_chg_r, last_chg_nxt;
  logic signed [47:0] chg_sum_r, chg_sum_nxt;
  logic signed [31:0] last_enr_r, last_enr_nxt;
  logic signed [47:0] enr_sum_r, enr_sum_nxt;

  logic signed [31:0] temp_q;

  sfd_div10 u_div10 (
    .din (raw),
    .quo (temp_q)
  );

  function automatic logic signed [31:0] mark_lo(
    input logic signed [31:0] v,
    input logic signed [31:0] lo,
    input logic warm,
    input logic live,
    input logic ok
  );
    logic signed [31:0] r;
    r = lo;
    if (warm) begin
      r = v;
    end else if (live && ok && (v < lo)) begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] mark_hi(
    input logic signed [31:0] v,
    input logic signed [31:0] hi,
    input logic live
  );
    return (live && (v > hi)) ? v : hi;
  endfunction

  logic               known;
  sfd_pkg::kind_t     kind;
  logic               warm, live, floor_ok;
  logic signed [33:0] r34;
  logic signed [31:0] volt1;
  logic signed [48:0] acc;

  always_comb begin
    known = (msg_id >= sfd_pkg::ID_FIRST) && (msg_id <= sfd_pkg::ID_LAST);
    kind  = known ? sfd_pkg::kind_t'(4'(msg_id - sfd_pkg::ID_BASE)) : sfd_pkg::KIND_IGNORED;
    total_nxt = (known && (total_r != sfd_pkg::FRAMES_MAX)) ? total_r + 16'd1 : total_r;
    warm = total_nxt < cfg.warmup_frames;
    live = total_nxt > cfg.warmup_frames;
    r34  = 34'(raw);
    floor_ok = r34 > $signed({3'b000, cfg.low_floor_mv});
    volt1 = sfd_pkg::sat32(r34 - (34'(second_r) + 34'(third_r)));
    acc   = '0;

    pack_nxt     = pack_r;
    second_nxt   = second_r;
    third_nxt    = third_r;
    marks_nxt    = marks_r;
    last_chg_nxt = last_chg_r;
    chg_sum_nxt  = chg_sum_r;
    last_enr_nxt = last_enr_r;
    enr_sum_nxt  = enr_sum_r;

    res = '0;
    res.kind        = kind;
    res.frames_seen = total_nxt;

    unique case (kind)
      sfd_pkg::KIND_CURRENT, sfd_pkg::KIND_POWER: begin
        res.main_value = 48'(raw);
      end
      sfd_pkg::KIND_PACK: begin
        pack_nxt = raw;
        marks_nxt[sfd_pkg::MARK_PACK_LO] =
          mark_lo(raw, marks_r[sfd_pkg::MARK_PACK_LO], warm, live, 1'b1);
        marks_nxt[sfd_pkg::MARK_PACK_HI] = mark_hi(raw, marks_r[sfd_pkg::MARK_PACK_HI], live);
        marks_nxt[sfd_pkg::MARK_V1_LO] =
          mark_lo(volt1, marks_r[sfd_pkg::MARK_V1_LO], warm, live, 1'b1);
        marks_nxt[sfd_pkg::MARK_V1_HI] = mark_hi(volt1, marks_r[sfd_pkg::MARK_V1_HI], live);
        res.main_value    = 48'(raw);
        res.derived_value = volt1;
        res.low_mark      = marks_nxt[sfd_pkg::MARK_PACK_LO];
        res.high_mark     = marks_nxt[sfd_pkg::MARK_PACK_HI];
        res.derived_low   = marks_nxt[sfd_pkg::MARK_V1_LO];
        res.derived_high  = marks_nxt[sfd_pkg::MARK_V1_HI];
      end
      sfd_pkg::KIND_VOLT2: begin
        if (r34 > $signed({3'b000, cfg.split_threshold_mv})) begin
          second_nxt = sfd_pkg::sat32(r34 - 34'(third_r));
        end else begin
          second_nxt = raw;
        end
        marks_nxt[sfd_pkg::MARK_V2_LO] =
          mark_lo(second_nxt, marks_r[sfd_pkg::MARK_V2_LO], warm, live, 1'b1);
        marks_nxt[sfd_pkg::MARK_V2_HI] =
          mark_hi(second_nxt, marks_r[sfd_pkg::MARK_V2_HI], live);
        res.main_value = 48'(second_nxt);
        res.low_mark   = marks_nxt[sfd_pkg::MARK_V2_LO];
        res.high_mark  = marks_nxt[sfd_pkg::MARK_V2_HI];
      end
      sfd_pkg::KIND_VOLT3: begin
        third_nxt = raw;
        marks_nxt[sfd_pkg::MARK_V3_LO] =
          mark_lo(raw, marks_r[sfd_pkg::MARK_V3_LO], warm, live, floor_ok);
        marks_nxt[sfd_pkg::MARK_V3_HI] = mark_hi(raw, marks_r[sfd_pkg::MARK_V3_HI], live);
        res.main_value = 48'(raw);
        res.low_mark   = marks_nxt[sfd_pkg::MARK_V3_LO];
        res.high_mark  = marks_nxt[sfd_pkg::MARK_V3_HI];
      end
      sfd_pkg::KIND_TEMP: begin
        res.main_value = 48'(temp_q);
      end
      sfd_pkg::KIND_CHARGE: begin
        acc          = 49'(chg_sum_r) + 49'(r34 - 34'(last_chg_r));
        chg_sum_nxt  = sfd_pkg::sat48(acc);
        last_chg_nxt = raw;
        res.main_value = chg_sum_nxt;
      end
      sfd_pkg::KIND_ENERGY: begin
        acc          = 49'(enr_sum_r) + 49'(r34 - 34'(last_enr_r));
        enr_sum_nxt  = sfd_pkg::sat48(acc);
        last_enr_nxt = raw;
        res.main_value = enr_sum_nxt;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r    <= '0;
      pack_r     <= '0;
      second_r   <= '0;
      third_r    <= '0;
      last_chg_r <= '0;
      chg_sum_r  <= '0;
      last_enr_r <= '0;
      enr_sum_r  <= '0;
      for (int i = 0; i < sfd_pkg::MARK_COUNT; i++) begin
        marks_r[i] <= '0;
      end
    end else if (adv) begin
      total_r    <= total_nxt;
      pack_r     <= pack_nxt;
      second_r   <= second_nxt;
      third_r    <= third_nxt;
      last_chg_r <= last_chg_nxt;
      chg_sum_r  <= chg_sum_nxt;
      last_enr_r <= last_enr_nxt;
      enr_sum_r  <= enr_sum_nxt;
      marks_r    <= marks_nxt;
    end
  end

  assign frame_total = total_r;

endmodule

FILE: sv/sensor_frame_decoder_minmax.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_frame_decoder_minmax
// decodes sensor messages into scaled values with low/high mark tracking
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one message word per handshake (valid/ready): identifier and
//           payload bytes 2..5 of a signed little-endian reading.
//   out_* : one result word per message (valid/ready), ignored identifiers
//           included with kind zero.
//   cfg_* : register write port (warm-up limit, split threshold, floor);
//           write only while no message is in flight.
// Path: an accepted message is loaded into the input register, then into the
//   result register, which raises out_valid; a held result delays the second.
// Throughput: one message per cycle unless a held result stalls; the state
//   update and the divide by ten are both combinational in the decode stage.
// Reset: synchronous; all measurement state, marks and accumulators go to
//   zero, registers return to their defaults, both channels empty.
// Stall: a held result keeps its register; one more message can wait in
//   the input register, after which in_ready drops until out_ready returns.
// ----------------------------------------------------------------------------
module sensor_frame_decoder_minmax (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [10:0]        in_message_id,
  input  logic [7:0]         in_byte2,
  input  logic [7:0]         in_byte3,
  input  logic [7:0]         in_byte4,
  input  logic [7:0]         in_byte5,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         out_kind,
  output logic signed [47:0] out_main_value,
  output logic signed [31:0] out_derived_value,
  output logic signed [31:0] out_low_mark,
  output logic signed [31:0] out_high_mark,
  output logic signed [31:0] out_derived_low,
  output logic signed [31:0] out_derived_high,
  output logic [15:0]        out_frames_seen
);

  sfd_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.warmup_frames      <= sfd_pkg::WARMUP_RESET;
      cfg_r.split_threshold_mv <= sfd_pkg::SPLIT_RESET;
      cfg_r.low_floor_mv       <= sfd_pkg::FLOOR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sfd_pkg::CFG_WARMUP: cfg_r.warmup_frames      <= cfg_wdata[15:0];
        sfd_pkg::CFG_SPLIT:  cfg_r.split_threshold_mv <= cfg_wdata;
        sfd_pkg::CFG_FLOOR:  cfg_r.low_floor_mv       <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // input register
  logic               s1_valid_r;
  logic [10:0]        s1_id_r;
  logic signed [31:0] s1_raw_r;
  logic               s1_adv;
  logic               out_valid_r;
  sfd_pkg::res_t      res_r;
  sfd_pkg::res_t      res_nxt;
  logic [15:0]        frame_total;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_id_r  <= in_message_id;
      s1_raw_r <= {in_byte5, in_byte4, in_byte3, in_byte2};
    end
  end

  sfd_state u_state (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (s1_adv),
    .msg_id      (s1_id_r),
    .raw         (s1_raw_r),
    .cfg         (cfg_r),
    .res         (res_nxt),
    .frame_total (frame_total)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = res_r.kind;
  assign out_main_value    = res_r.main_value;
  assign out_derived_value = res_r.derived_value;
  assign out_low_mark      = res_r.low_mark;
  assign out_high_mark     = res_r.high_mark;
  assign out_derived_low   = res_r.derived_low;
  assign out_derived_high  = res_r.derived_high;
  assign out_frames_seen   = res_r.frames_seen;

  a_ignored_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && (res_nxt.kind == sfd_pkg::KIND_IGNORED) |=> $stable(frame_total))
    else $error("frame count moved on an ignored word");

  a_ignored_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (res_r.kind == sfd_pkg::KIND_IGNORED) |->
      (res_r.main_value == '0) && (res_r.low_mark == '0) && (res_r.high_mark == '0))
    else $error("ignored word carries values");

  a_derived_only_pack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (res_r.kind != sfd_pkg::KIND_PACK) |->
      (res_r.derived_value == '0) && (res_r.derived_low == '0) &&
      (res_r.derived_high == '0))
    else $error("voltage 1 fields set outside pack voltage");

  a_ready_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && out_valid_r && !out_ready)
    else $error("input stalled with room in the pipeline");

  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> (res_r.frames_seen == frame_total))
    else $error("reported frame count differs from state");

endmodule
